@@ rtl/rau_pkg.sv @@
package rau_pkg;

  // opcodes
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_INC   = 3'd4;
  localparam logic [2:0] OP_CMP   = 3'd5;
  localparam logic [2:0] OP_TRUNC = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // multiplier step selects
  localparam logic [1:0] MSEL_P1 = 2'd0;
  localparam logic [1:0] MSEL_P2 = 2'd1;
  localparam logic [1:0] MSEL_P3 = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       shift_en;
    logic       comb1;
    logic       comb2;
    logic       gcd_step;
    logic       g_set;
    logic       tr_set;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic early;
    logic is_cmp;
    logic is_trunc;
    logic gcd_done;
    logic div_last;
  } stat_t;

endpackage

@@ rtl/rau_ctrl.sv @@
module rau_ctrl
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_TRS, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
    S_COMB1, S_COMB2, S_GCD, S_GSET, S_DIVI, S_DIV, S_FIN
  } state_t;

  state_t state, state_next;
  logic   out_load;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CHK;
      S_CHK: begin
        if (stat.early) state_next = S_FIN;
        else if (stat.is_trunc) state_next = S_TRS;
        else state_next = S_MUL1;
      end
      S_TRS:   state_next = S_DIVI;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MUL3;
      S_MUL3:  state_next = S_MUL4;
      S_MUL4:  state_next = stat.is_cmp ? S_FIN : S_COMB1;
      S_COMB1: state_next = S_COMB2;
      S_COMB2: state_next = S_GCD;
      S_GCD:   if (stat.gcd_done) state_next = S_GSET;
      S_GSET:  state_next = S_DIVI;
      S_DIVI:  state_next = S_DIV;
      S_DIV:   if (stat.div_last) state_next = S_FIN;
      S_FIN:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.mul_en   = (state == S_MUL1) || (state == S_MUL2) || (state == S_MUL3);
    cmd.mul_sel  = (state == S_MUL1) ? MSEL_P1 : (state == S_MUL2) ? MSEL_P2 : MSEL_P3;
    cmd.shift_en = (state == S_MUL2) || (state == S_MUL3) || (state == S_MUL4);
    cmd.comb1    = (state == S_COMB1);
    cmd.comb2    = (state == S_COMB2);
    cmd.gcd_step = (state == S_GCD) && !stat.gcd_done;
    cmd.g_set    = (state == S_GSET);
    cmd.tr_set   = (state == S_TRS);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.out_load = out_load;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/rau_dp.sv @@
module rau_dp
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output stat_t              stat,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic               is_greater,
  output logic               is_less,
  output logic [1:0]         status
);

  localparam logic [63:0] MAX_POS = (64'd1 << (WIDTH - 1)) - 64'd1;

  // operand registers, sign and magnitude
  logic [2:0]  op;
  logic        early;
  logic [1:0]  early_st;
  logic        a_neg, b_neg;
  logic [31:0] a_nm, a_dm, b_nm, b_dm;

  // products and fraction
  logic [63:0] pm;
  logic        ps;
  logic [63:0] px, py, pz;
  logic [63:0] un, ud;
  logic        neg;

  // gcd and division
  logic [63:0] ga, gb, dv;
  logic [5:0]  k;
  logic [63:0] q0, q1, r0, r1;
  logic [5:0]  cnt;

  // input decode
  logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic        uses_b, zero_err;
  assign an_mag   = a_num[31] ? 32'(-a_num) : 32'(a_num);
  assign ad_mag   = a_den[31] ? 32'(-a_den) : 32'(a_den);
  assign bn_mag   = b_num[31] ? 32'(-b_num) : 32'(b_num);
  assign bd_mag   = b_den[31] ? 32'(-b_den) : 32'(b_den);
  assign uses_b   = (req_type <= OP_DIV) || (req_type == OP_CMP);
  assign zero_err = (a_den == 32'sd0) || (uses_b && (b_den == 32'sd0)) ||
                    ((req_type == OP_DIV) && (b_num == 32'sd0));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req_type;
      early    <= (req_type == OP_NONE) || zero_err;
      early_st <= (req_type == OP_NONE) ? ST_OK : ST_ZERO;
      a_neg    <= a_num[31] ^ a_den[31];
      a_nm     <= an_mag;
      a_dm     <= ad_mag;
      if (req_type == OP_INC) begin
        b_neg <= 1'b0;
        b_nm  <= 32'd1;
        b_dm  <= 32'd1;
      end else begin
        b_neg <= b_num[31] ^ b_den[31];
        b_nm  <= bn_mag;
        b_dm  <= bd_mag;
      end
    end
  end

  // multiplier operand select
  logic [31:0] m_x, m_y;
  logic        m_s;
  always_comb begin
    case (cmd.mul_sel)
      MSEL_P1: begin
        m_x = a_nm;
        m_y = (op == OP_MUL) ? b_nm : b_dm;
        m_s = a_neg ^ ((op == OP_MUL) && b_neg);
      end
      MSEL_P2: begin
        m_x = b_nm;
        m_y = a_dm;
        m_s = b_neg;
      end
      default: begin
        m_x = a_dm;
        m_y = (op == OP_DIV) ? b_nm : b_dm;
        m_s = (op == OP_DIV) && b_neg;
      end
    endcase
  end

  // product magnitude, then signed into the product line
  logic [63:0] p_conv;
  assign p_conv = ps ? (64'd0 - pm) : pm;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pm <= m_x * m_y;
      ps <= m_s;
    end
    if (cmd.shift_en) begin
      px <= py;
      py <= pz;
      pz <= p_conv;
    end else if (cmd.comb1) begin
      if (op == OP_ADD || op == OP_INC) px <= px + py;
      else if (op == OP_SUB) px <= px - py;
    end
  end

  // magnitudes and sign of the fraction, gcd iteration
  logic [63:0] ax, az, g_raw, ga_m_gb, gb_m_ga;
  assign ax      = px[63] ? (64'd0 - px) : px;
  assign az      = pz[63] ? (64'd0 - pz) : pz;
  assign g_raw   = (ga | gb) << k;
  assign ga_m_gb = ga - gb;
  assign gb_m_ga = gb - ga;

  always_ff @(posedge clk) begin
    if (cmd.comb2) begin
      un  <= ax;
      ud  <= az;
      neg <= px[63] ^ pz[63];
      ga  <= ax;
      gb  <= az;
      k   <= 6'd0;
    end else if (cmd.tr_set) begin
      un  <= {32'd0, a_nm};
      ud  <= 64'd1;
      neg <= a_neg;
      dv  <= {32'd0, a_dm};
    end else if (cmd.g_set) begin
      dv <= (g_raw == 64'd0) ? 64'd1 : g_raw;
    end else if (cmd.gcd_step) begin
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + 6'd1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga >= gb) begin
        ga <= ga_m_gb >> 1;
      end else begin
        gb <= gb_m_ga >> 1;
      end
    end
  end

  // two restoring division lanes sharing one divisor
  logic [64:0] dvx, r0s, r1s, d0, d1;
  logic        ge0, ge1;
  assign dvx = {1'b0, dv};
  assign r0s = {r0, q0[63]};
  assign r1s = {r1, q1[63]};
  assign d0  = r0s - dvx;
  assign d1  = r1s - dvx;
  assign ge0 = (r0s >= dvx);
  assign ge1 = (r1s >= dvx);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      q0  <= un;
      q1  <= ud;
      r0  <= 64'd0;
      r1  <= 64'd0;
      cnt <= 6'd0;
    end else if (cmd.div_step) begin
      q0  <= {q0[62:0], ge0};
      q1  <= {q1[62:0], ge1};
      r0  <= ge0 ? d0[63:0] : r0s[63:0];
      r1  <= ge1 ? d1[63:0] : r1s[63:0];
      cnt <= cnt + 6'd1;
    end
  end

  assign stat.early    = early;
  assign stat.is_cmp   = (op == OP_CMP);
  assign stat.is_trunc = (op == OP_TRUNC);
  assign stat.gcd_done = (ga == 64'd0) || (gb == 64'd0);
  assign stat.div_last = (cnt == 6'd63);

  // range check and result assembly
  logic [63:0] qd, lim;
  logic        ovf;
  logic [31:0] mag32;
  assign qd    = (op == OP_TRUNC) ? 64'd1 : q1;
  assign lim   = neg ? (MAX_POS + 64'd1) : MAX_POS;
  assign ovf   = (q0 > lim) || (qd == 64'd0) || (qd > MAX_POS);
  assign mag32 = q0[31:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_num    <= '0;
      res_den    <= '0;
      is_equal   <= 1'b0;
      is_greater <= 1'b0;
      is_less    <= 1'b0;
      if (early) begin
        status <= early_st;
      end else if (op == OP_CMP) begin
        status     <= ST_OK;
        is_equal   <= (px == py);
        is_greater <= ($signed(px) > $signed(py));
        is_less    <= ($signed(px) < $signed(py));
      end else if (ovf) begin
        status <= ST_OVF;
      end else begin
        status  <= ST_OK;
        res_num <= (neg && (mag32 != 32'd0)) ? $signed(32'd0 - mag32) : $signed(mag32);
        res_den <= qd[30:0];
      end
    end
  end

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// channel   signals                                             dir
// in        in_valid in_ready req_type a_num a_den b_num b_den  input transfer
// out       out_valid out_ready res_num res_den is_equal        output transfer
//           is_greater is_less status
// one item at a time
// errors and opcode seven go straight to finish, compare after the multiply states
// truncate goes to division; other ops: multiply, binary gcd loop, division
// rst is synchronous and clears the controller and output valid
// a finished result waits in the output register; the next item may enter meanwhile
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               is_equal,
  output logic               is_greater,
  output logic               is_less,
  output logic [1:0]         status
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic datapath
  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .req_type   (req_type),
    .a_num      (a_num),
    .a_den      (a_den),
    .b_num      (b_num),
    .b_den      (b_den),
    .stat       (stat),
    .res_num    (res_num),
    .res_den    (res_den),
    .is_equal   (is_equal),
    .is_greater (is_greater),
    .is_less    (is_less),
    .status     (status)
  );

endmodule

@@ tb/rau_checker.sv @@
`timescale 1ns / 1ps

module rau_checker
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] res_num,
  input  logic [30:0]        res_den,
  input  logic               is_equal,
  input  logic               is_greater,
  input  logic               is_less,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 outstanding
);

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               eq;
    logic               gt;
    logic               lt;
    logic [1:0]         st;
  } frac_res_t;

  frac_res_t expected_fracs[$];

  function automatic frac_res_t cleared(logic [1:0] st);
    frac_res_t r;
    r.num = '0;
    r.den = '0;
    r.eq  = 1'b0;
    r.gt  = 1'b0;
    r.lt  = 1'b0;
    r.st  = st;
    return r;
  endfunction

  // range check of a sign and magnitude pair against WIDTH
  function automatic frac_res_t fit_value(bit neg, logic [65:0] un, logic [65:0] ud);
    logic [65:0] maxpos;
    logic [65:0] lim;
    frac_res_t   r;
    maxpos = (66'd1 << (WIDTH - 1)) - 66'd1;
    if (un == 0) neg = 1'b0;
    lim = neg ? maxpos + 66'd1 : maxpos;
    if (un > lim || ud == 0 || ud > maxpos) return cleared(ST_OVF);
    r = cleared(ST_OK);
    r.num = neg ? -un[31:0] : un[31:0];
    r.den = ud[30:0];
    return r;
  endfunction

  function automatic logic [65:0] magnitude(logic signed [65:0] v);
    return v < 0 ? -v : v;
  endfunction

  // reduce n/d by the gcd, sign carried by the numerator
  function automatic frac_res_t reduce_frac(logic signed [65:0] n, logic signed [65:0] d);
    bit          neg;
    logic [65:0] un;
    logic [65:0] ud;
    logic [65:0] x;
    logic [65:0] y;
    logic [65:0] t;
    neg = (n < 0) != (d < 0);
    un = magnitude(n);
    ud = magnitude(d);
    x = un;
    y = ud;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 66'd1;
    return fit_value(neg, un / x, ud / x);
  endfunction

  function automatic frac_res_t compute_frac(logic [2:0] op, logic signed [31:0] pa_num,
                                             logic signed [31:0] pa_den,
                                             logic signed [31:0] pb_num,
                                             logic signed [31:0] pb_den);
    logic signed [65:0] an;
    logic signed [65:0] ad;
    logic signed [65:0] bn;
    logic signed [65:0] bd;
    logic signed [65:0] l;
    logic signed [65:0] r;
    bit                 uses_b;
    frac_res_t          res;
    an = pa_num;
    ad = pa_den;
    bn = pb_num;
    bd = pb_den;
    uses_b = (op <= OP_DIV) || (op == OP_CMP);
    if (op == OP_NONE) return cleared(ST_OK);
    if (ad == 0 || (uses_b && bd == 0)) return cleared(ST_ZERO);
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    case (op)
      OP_ADD: res = reduce_frac(an * bd + bn * ad, ad * bd);
      OP_SUB: res = reduce_frac(an * bd - bn * ad, ad * bd);
      OP_MUL: res = reduce_frac(an * bn, ad * bd);
      OP_DIV: begin
        if (bn == 0) res = cleared(ST_ZERO);
        else res = reduce_frac(an * bd, ad * bn);
      end
      OP_INC: res = reduce_frac(an + ad, ad);
      OP_CMP: begin
        l = an * bd;
        r = bn * ad;
        res = cleared(ST_OK);
        res.eq = (l == r);
        res.gt = (l > r);
        res.lt = (l < r);
      end
      default: res = fit_value(an < 0, magnitude(an) / ad, 66'd1);
    endcase
    return res;
  endfunction

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    frac_res_t e;
    if (rst) begin
      errors = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_fracs.push_back(compute_frac(req_type, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (expected_fracs.size() == 0) begin
          $display("%0t: result with nothing expected: num %0d den %0d st %0d",
                   $time, res_num, res_den, status);
          errors = errors + 1;
        end else begin
          e = expected_fracs.pop_front();
          if (res_num !== e.num) begin
            $display("%0t: res_num expected %0d actual %0d", $time, e.num, res_num);
            errors = errors + 1;
          end
          if (res_den !== e.den) begin
            $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den);
            errors = errors + 1;
          end
          if (is_equal !== e.eq) begin
            $display("%0t: is_equal expected %0b actual %0b", $time, e.eq, is_equal);
            errors = errors + 1;
          end
          if (is_greater !== e.gt) begin
            $display("%0t: is_greater expected %0b actual %0b", $time, e.gt, is_greater);
            errors = errors + 1;
          end
          if (is_less !== e.lt) begin
            $display("%0t: is_less expected %0b actual %0b", $time, e.lt, is_less);
            errors = errors + 1;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors = errors + 1;
          end
        end
      end
      outstanding <= expected_fracs.size();
    end
  end

endmodule

@@ tb/rational_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps

module rational_arithmetic_unit_tb
  import rau_pkg::*;
;

  localparam int MAX_CYCLES = 1000000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         req_type;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               is_equal;
  logic               is_greater;
  logic               is_less;
  logic [1:0]         status;
  int                 errors;
  int                 outstanding;
  int                 burst_left;
  int                 cycles;

  rational_arithmetic_unit #(.WIDTH(32)) dut (.*);

  rau_checker #(.WIDTH(32)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > MAX_CYCLES) begin
        $display("rational_arithmetic_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int k;
    int mode;
    k = 0;
    mode = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      k++;
      if (k == 4000) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      if (k % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // one input transfer, with bursts and gaps
  task automatic send_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    req_type <= op;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32) - 16;
      4, 5:       v = $urandom_range(0, 65536) - 32768;
      6, 7:       v = $urandom;
      8: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'd1;
          3: v = 32'hffff_ffff;
          default: v = 32'd0;
        endcase
      end
      default: v = 32'd1 << $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_denominator();
    logic [31:0] v;
    v = rand_operand();
    if (v == 0 && $urandom_range(0, 7) != 0) v = 32'd1;
    return v;
  endfunction

  // stimulus
  initial begin
    logic [2:0] op;
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = OP_ADD;
    a_num      = '0;
    a_den      = '0;
    b_num      = '0;
    b_den      = '0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: each op, zero denominators, zero result, overflow, extremes
    send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(OP_ADD, 32'd1, 32'd2, -32'sd1, 32'd2);
    send_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    send_item(OP_SUB, 32'd3, 32'd4, 32'd1, -32'sd4);
    send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(OP_MUL, 32'd0, -32'sd5, 32'd7, 32'd3);
    send_item(OP_DIV, 32'd2, 32'd3, 32'd0, 32'd5);
    send_item(OP_DIV, 32'd2, 32'd3, -32'sd4, 32'd9);
    send_item(OP_INC, 32'd5, -32'sd7, 32'd0, 32'd0);
    send_item(OP_INC, 32'h7fff_ffff, 32'd1, 32'd3, 32'd3);
    send_item(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    send_item(OP_CMP, 32'd2, 32'd3, 32'd1, 32'd2);
    send_item(OP_CMP, -32'sd1, 32'd3, 32'd1, -32'sd4);
    send_item(OP_TRUNC, 32'd17, 32'd5, 32'd0, 32'd0);
    send_item(OP_TRUNC, -32'sd17, 32'd5, 32'd1, 32'd1);
    send_item(OP_TRUNC, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
    send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(OP_SUB, 32'd1, 32'd1, 32'd1, 32'd0);
    send_item(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
    send_item(OP_TRUNC, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(OP_NONE, 32'hffff_ffff, 32'd0, 32'h8000_0000, 32'd0);

    // random items
    for (int i = 0; i < 700; i++) begin
      if (i == 350) begin
        // sender pause until the block drains
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      op = ($urandom_range(0, 29) == 0) ? OP_NONE : 3'($urandom_range(0, 6));
      send_item(op, rand_operand(), rand_denominator(), rand_operand(), rand_denominator());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("rational_arithmetic_unit: match");
    end else begin
      $display("rational_arithmetic_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
tb/rau_checker.sv
tb/rational_arithmetic_unit_tb.sv
